>>> rtl/json_string_escaper_utf8_unit_macros.svh
// Assertion macros for the JSON string escaper checker.
// Used by jse_checker.sv only; expects clk_i and rst_ni in scope.
`ifndef JSON_STRING_ESCAPER_UTF8_UNIT_MACROS_SVH
`define JSON_STRING_ESCAPER_UTF8_UNIT_MACROS_SVH

// Checked on every clock edge outside reset.
`define JSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define JSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/jse_pkg.sv
// Shared types, constants and helper functions of the JSON string escaper.
// No dependencies; used by the top level, jse_front, jse_queue and jse_back.
package jse_pkg;

  localparam int unsigned QDepth = 4;

  // Characters used when building escape sequences.
  localparam logic [7:0] ChQuest  = 8'h3F;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChD      = 8'h64;
  localparam logic [7:0] CtlLf    = 8'h0A;
  localparam logic [7:0] CtlCr    = 8'h0D;
  localparam logic [7:0] CtlTab   = 8'h09;

  // What the back end spells out after the leading '?' bytes.
  typedef enum logic [2:0] {
    KindNone,   // only '?' bytes, if any
    KindLit1,   // data[7:0] as is
    KindEsc2,   // backslash, data[7:0]
    KindU00,    // \u00xx of data[7:0]
    KindPass2,  // data[15:8], data[7:0]
    KindPass3,  // data[23:16], data[15:8], data[7:0]
    KindSurr    // \uD8xx\uDCxx, data[19:0] is the offset above 0x10000
  } kind_e;

  typedef struct packed {
    logic [2:0]  qcnt;
    kind_e       kind;
    logic [23:0] data;
    logic        last;
  } desc_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    hex_digit = (nib < 4'd10) ? (8'h30 + {4'b0, nib}) : (8'h57 + {4'b0, nib});
  endfunction

  // Sequence length of a lead byte, 0 when it is not a valid lead.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    if (b >= 8'hC2 && b <= 8'hDF)      lead_len = 3'd2;
    else if (b >= 8'hE0 && b <= 8'hEF) lead_len = 3'd3;
    else if (b >= 8'hF0 && b <= 8'hF4) lead_len = 3'd4;
    else                               lead_len = 3'd0;
  endfunction

  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hBF;
    if (lead == 8'hE0) lo = 8'hA0;
    if (lead == 8'hED) hi = 8'h9F;
    if (lead == 8'hF0) lo = 8'h90;
    if (lead == 8'hF4) hi = 8'h8F;
    second_ok = (b >= lo) && (b <= hi);
  endfunction

  function automatic logic [3:0] kind_len(input kind_e k);
    unique case (k)
      KindNone:  kind_len = 4'd0;
      KindLit1:  kind_len = 4'd1;
      KindEsc2:  kind_len = 4'd2;
      KindU00:   kind_len = 4'd6;
      KindPass2: kind_len = 4'd2;
      KindPass3: kind_len = 4'd3;
      KindSurr:  kind_len = 4'd12;
      default:   kind_len = 4'd0;
    endcase
  endfunction

endpackage

>>> rtl/json_string_escaper_utf8_unit.sv
// Streaming JSON string escaper with UTF-8 validation, top level.
// Instantiates jse_front, jse_queue and jse_back; depends on jse_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one raw string byte per beat,
//   with end_of_string_i marking the final byte of a string.
//   Output channel (out_valid_o/out_ready_i) gives one escaped byte per beat;
//   last_of_string_o flags the final output byte of a string.
// Path: the edge that accepts a byte that yields output writes its descriptor
//   into the queue; a later edge, once the back end reaches it and the output
//   is not stalled, loads its first output byte into the output register.
// Throughput: one output byte per cycle while the receiver does not stall,
//   set by the single back-end byte sequencer. Plain ASCII runs at one input
//   beat per cycle; an escape or a UTF-8 sequence is spelled out byte by byte
//   (2 bytes for short escapes, 6 for \u00xx, 12 for a surrogate pair).
//   UTF-8 leads and middle bytes are absorbed by the front with no output.
// Stalls: the descriptor queue (QDepth entries) lets the front keep taking
//   beats while the receiver stalls; in_ready_o drops only when it is full.
// Reset: rst_ni clears the held-byte count, queue and output valid; the empty
//   queue keeps in_ready_o high, so the block accepts beats right after reset.
module json_string_escaper_utf8_unit #(
  parameter int unsigned QDepth = jse_pkg::QDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_string_o
);

  logic           accept;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  jse_pkg::desc_t front_desc;
  jse_pkg::desc_t head_desc;

  // Front keeps going as long as there is room for one more descriptor.
  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  jse_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i        (accept),
    .in_byte_i,
    .end_of_string_i,
    .push_o          (push),
    .desc_o          (front_desc)
  );

  jse_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .desc_i  (front_desc),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .desc_o  (head_desc)
  );

  // Back end drains the queue head a byte at a time.
  jse_back u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i    (!empty),
    .head_i          (head_desc),
    .pop_o           (pop),
    .out_valid_o,
    .out_ready_i,
    .out_byte_o,
    .last_of_string_o
  );

endmodule

>>> rtl/jse_front.sv
// Front end: takes input beats, tracks held UTF-8 bytes, builds descriptors.
// Depends on jse_pkg.
module jse_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        in_byte_i,
  input  logic              end_of_string_i,
  output logic              push_o,
  output jse_pkg::desc_t    desc_o
);

  logic [7:0] held_q [3];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en;
  logic [1:0] wr_idx;

  always_comb begin
    logic [2:0]  len;
    logic [2:0]  pos;
    logic        ok;
    logic        fresh;
    logic [2:0]  qbase;
    logic [2:0]  newcnt;
    logic [20:0] cp;
    logic [20:0] off;
    jse_pkg::kind_e kind;
    logic [23:0] data;

    len    = jse_pkg::lead_len(held_q[0]);
    pos    = {1'b0, cnt_q};
    ok     = 1'b0;
    fresh  = 1'b0;
    qbase  = 3'd0;
    newcnt = 3'd0;
    kind   = jse_pkg::KindNone;
    data   = 24'd0;
    wr_en  = 1'b0;
    wr_idx = cnt_q;
    cp     = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0], in_byte_i[5:0]};
    off    = cp - 21'h10000;

    if (cnt_q == 2'd0) begin
      fresh = 1'b1;
    end else begin
      if (pos == 3'd1) ok = jse_pkg::second_ok(held_q[0], in_byte_i);
      else             ok = (in_byte_i >= 8'h80) && (in_byte_i <= 8'hBF);
      if (len == 3'd0 || pos >= len) ok = 1'b0;

      if (!ok) begin
        qbase = pos;
        fresh = 1'b1;
      end else if (pos + 3'd1 == len) begin
        priority if (len == 3'd4) begin
          kind = jse_pkg::KindSurr;
          data = {4'd0, off[19:0]};
        end else if (len == 3'd3) begin
          kind = jse_pkg::KindPass3;
          data = {held_q[0], held_q[1], in_byte_i};
        end else begin
          kind = jse_pkg::KindPass2;
          data = {8'd0, held_q[0], in_byte_i};
        end
      end else begin
        wr_en  = 1'b1;
        newcnt = pos + 3'd1;
      end
    end

    if (fresh) begin
      data = {16'd0, in_byte_i};
      if (in_byte_i < 8'h80) begin
        priority if (in_byte_i == jse_pkg::ChQuote || in_byte_i == jse_pkg::ChBslash) begin
          kind = jse_pkg::KindEsc2;
        end else if (in_byte_i == jse_pkg::CtlLf) begin
          kind = jse_pkg::KindEsc2;
          data = {16'd0, jse_pkg::ChN};
        end else if (in_byte_i == jse_pkg::CtlCr) begin
          kind = jse_pkg::KindEsc2;
          data = {16'd0, jse_pkg::ChR};
        end else if (in_byte_i == jse_pkg::CtlTab) begin
          kind = jse_pkg::KindEsc2;
          data = {16'd0, jse_pkg::ChT};
        end else if (in_byte_i < 8'h20) begin
          kind = jse_pkg::KindU00;
        end else begin
          kind = jse_pkg::KindLit1;
        end
      end else if (jse_pkg::lead_len(in_byte_i) != 3'd0) begin
        kind   = jse_pkg::KindNone;
        wr_en  = 1'b1;
        wr_idx = 2'd0;
        newcnt = 3'd1;
      end else begin
        kind = jse_pkg::KindLit1;
        data = {16'd0, jse_pkg::ChQuest};
      end
    end

    // End of string: whatever is still held turns into '?' bytes.
    if (end_of_string_i && newcnt != 3'd0) begin
      qbase  = qbase + newcnt;
      newcnt = 3'd0;
    end

    cnt_d         = newcnt[1:0];
    desc_o.qcnt   = qbase;
    desc_o.kind   = kind;
    desc_o.data   = data;
    desc_o.last   = end_of_string_i;
    push_o        = accept_i && (qbase != 3'd0 || kind != jse_pkg::KindNone);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && wr_en) begin
      held_q[wr_idx] <= in_byte_i;
    end
  end

endmodule

>>> rtl/jse_queue.sv
// Descriptor queue between front and back end, register based.
// Depends on jse_pkg.
module jse_queue #(
  parameter int unsigned Depth = jse_pkg::QDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jse_pkg::desc_t desc_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output jse_pkg::desc_t desc_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  jse_pkg::desc_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    bump = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign desc_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? bump(wr_q) : wr_q;
    rd_d  = pop_i ? bump(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= desc_i;
    end
  end

endmodule

>>> rtl/jse_back.sv
// Back end: spells out one descriptor a byte per cycle into the output register unless stalled.
// Depends on jse_pkg.
module jse_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  jse_pkg::desc_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           last_of_string_o
);

  logic [3:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       step;
  logic       final_b;

  always_comb begin
    logic [3:0]  total;
    logic [3:0]  j;
    logic [23:0] d;
    logic [7:0]  b;

    d     = head_i.data;
    total = {1'b0, head_i.qcnt} + jse_pkg::kind_len(head_i.kind);
    j     = idx_q - {1'b0, head_i.qcnt};
    b     = jse_pkg::ChQuest;

    if (idx_q >= {1'b0, head_i.qcnt}) begin
      unique case (head_i.kind)
        jse_pkg::KindLit1: b = d[7:0];
        jse_pkg::KindEsc2: b = (j == 4'd0) ? jse_pkg::ChBslash : d[7:0];
        jse_pkg::KindPass2: b = (j == 4'd0) ? d[15:8] : d[7:0];
        jse_pkg::KindPass3: begin
          unique case (j)
            4'd0:    b = d[23:16];
            4'd1:    b = d[15:8];
            default: b = d[7:0];
          endcase
        end
        jse_pkg::KindU00: begin
          unique case (j)
            4'd0:    b = jse_pkg::ChBslash;
            4'd1:    b = jse_pkg::ChU;
            4'd2:    b = jse_pkg::ChZero;
            4'd3:    b = jse_pkg::ChZero;
            4'd4:    b = jse_pkg::hex_digit(d[7:4]);
            default: b = jse_pkg::hex_digit(d[3:0]);
          endcase
        end
        jse_pkg::KindSurr: begin
          unique case (j)
            4'd0, 4'd6: b = jse_pkg::ChBslash;
            4'd1, 4'd7: b = jse_pkg::ChU;
            4'd2, 4'd8: b = jse_pkg::ChD;
            4'd3:       b = jse_pkg::hex_digit({2'b10, d[19:18]});
            4'd4:       b = jse_pkg::hex_digit(d[17:14]);
            4'd5:       b = jse_pkg::hex_digit(d[13:10]);
            4'd9:       b = jse_pkg::hex_digit({2'b11, d[9:8]});
            4'd10:      b = jse_pkg::hex_digit(d[7:4]);
            default:    b = jse_pkg::hex_digit(d[3:0]);
          endcase
        end
        default: b = jse_pkg::ChQuest;
      endcase
    end

    step    = head_valid_i && (!vld_q || out_ready_i);
    final_b = (idx_q + 4'd1 >= total);
    pop_o   = step && final_b;

    idx_d  = idx_q;
    vld_d  = vld_q && !out_ready_i;
    byte_d = byte_q;
    last_d = last_q;
    if (step) begin
      idx_d  = final_b ? 4'd0 : idx_q + 4'd1;
      vld_d  = 1'b1;
      byte_d = b;
      last_d = head_i.last && final_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 4'd0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o      = vld_q;
  assign out_byte_o       = byte_q;
  assign last_of_string_o = last_q;

endmodule

>>> rtl/jse_checker.sv
// Port-level checker for the JSON string escaper, bound to the top level.
// Depends on json_string_escaper_utf8_unit_macros.svh.
`include "json_string_escaper_utf8_unit_macros.svh"

module jse_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       last_of_string_o
);

  logic       out_stall;
  logic [8:0] out_beat;

  assign out_stall = out_valid_o && !out_ready_i;
  assign out_beat  = {out_byte_o, last_of_string_o};

  // A stalled output beat stays up.
  `JSE_ASSERT(a_out_hold, out_stall |=> out_valid_o, "output beat dropped")

  // A stalled output beat keeps its payload.
  `JSE_ASSERT(a_out_stable, out_stall |=> $stable(out_beat), "stalled output payload changed")

  // Every control byte below 0x20 is escaped, so none reaches the output.
  `JSE_ASSERT(a_no_ctrl, out_valid_o |-> out_byte_o >= 8'h20, "raw control byte on output")

  // Output valid stays low through reset.
  `JSE_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_o, "output valid during reset")

endmodule

bind json_string_escaper_utf8_unit jse_checker u_jse_checker (.*);
